// ----- sv/utfcu_pkg.sv -----
// Package with the item types, codes and constants of the UTF code unit decoder.
package utfcu_pkg;

    localparam logic [1:0] ENC_UTF8   = 2'd0;
    localparam logic [1:0] ENC_UTF16  = 2'd1;
    localparam logic [1:0] ENC_UTF32  = 2'd2;
    localparam logic [1:0] ENC_UNUSED = 2'd3;

    localparam logic [1:0] KIND_CODE_POINT = 2'd0;
    localparam logic [1:0] KIND_BAD_LEAD   = 2'd1;
    localparam logic [1:0] KIND_END        = 2'd2;

    localparam logic [1:0] REG_ENCODING   = 2'd0;
    localparam logic [1:0] REG_SKIP_COUNT = 2'd1;
    localparam logic [1:0] REG_CHAR_END   = 2'd2;
    localparam logic [1:0] REG_BYTE_LIMIT = 2'd3;

    localparam logic [31:0] SURR_OFFSET = 32'hFCA0_2400;

    localparam int BUDGET_WIDTH = 18;

    typedef struct packed {
        logic [31:0] unit;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  kind;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [2:0]  cost;
        logic [31:0] init;
        logic        bad;
    } lead_info_t;

endpackage

// ----- sv/utf_code_unit_decoder_unit.sv -----
// Top level of the UTF code unit decoder: input register, decode pass and result register.
// The decoder takes one code unit item per clock and gives at most one result item for it;
// the item passes through the input register and then the result register. The
// rate is one item per cycle, set by the single decode pass that reads the character state
// and writes the result register in the same cycle; a stalled result keeps its item in the
// input register, and a new item is taken only while that register is empty or moving on.
// Configuration writes are taken at any time, one per cycle, and must only
// be made while the decoder is idle. There are no memories and no clearing pass after reset.
module utf_code_unit_decoder_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  utfcu_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output utfcu_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import utfcu_pkg::*;

    localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [1:0]                     encoding_reg;
    logic [15:0]                    skip_count_reg;
    logic [15:0]                    char_end_reg;
    logic [15:0]                    byte_limit_reg;

    logic                           hold_valid_reg;
    in_item_t                       hold_item_reg;
    logic                           result_valid_reg;
    out_item_t                      result_reg;

    logic [2:0]                     pending_reg, pending_next;
    logic [31:0]                    acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]         index_reg, index_next;
    logic signed [BUDGET_WIDTH-1:0] budget_reg, budget_next;
    logic                           finished_reg, finished_next;

    logic                           fire;
    logic                           emit;
    out_item_t                      emit_item;
    logic [31:0]                    unit_m;
    lead_info_t                     lead;

    logic [2:0]                     pend_e;
    logic [31:0]                    acc_e;
    logic [COUNT_WIDTH-1:0]         index_e;
    logic signed [BUDGET_WIDTH-1:0] budget_e;
    logic                           finished_e;
    logic                           skipping;
    logic                           done_char;
    logic [31:0]                    done_cp;
    logic [1:0]                     done_kind;
    logic [31:0]                    acc_shift;

    assign cfg_ready    = 1'b1;
    assign fire         = hold_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !hold_valid_reg || fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        unique case (encoding_reg)
            ENC_UTF8:  unit_m = {24'd0, hold_item_reg.unit[7:0]};
            ENC_UTF16: unit_m = {16'd0, hold_item_reg.unit[15:0]};
            default:   unit_m = hold_item_reg.unit;
        endcase
    end

    utfcu_lead u_lead (
        .encoding (encoding_reg),
        .unit     (unit_m),
        .info     (lead)
    );

    always_comb
    begin
        if (hold_item_reg.restart)
        begin
            pend_e     = 3'd0;
            acc_e      = 32'd0;
            index_e    = '0;
            budget_e   = BUDGET_WIDTH'({2'b00, byte_limit_reg});
            finished_e = 1'b0;
        end
        else
        begin
            pend_e     = pending_reg;
            acc_e      = acc_reg;
            index_e    = index_reg;
            budget_e   = budget_reg;
            finished_e = finished_reg;
        end

        skipping      = CMP_WIDTH'(index_e) < CMP_WIDTH'(skip_count_reg);
        acc_shift     = (acc_e << 6) + {26'd0, unit_m[5:0]};
        pending_next  = pend_e;
        acc_next      = acc_e;
        index_next    = index_e;
        budget_next   = budget_e;
        finished_next = finished_e;
        emit          = 1'b0;
        emit_item     = '{code_point: 32'd0, kind: KIND_END};
        done_char     = 1'b0;
        done_cp       = 32'd0;
        done_kind     = KIND_CODE_POINT;

        if (finished_e || encoding_reg == ENC_UNUSED)
        begin
            emit = 1'b0;
        end
        else if (pend_e != 3'd0 && encoding_reg == ENC_UTF8)
        begin
            pending_next = pend_e - 3'd1;
            acc_next     = acc_shift;
            if (pend_e == 3'd1)
            begin
                done_char = 1'b1;
                done_cp   = acc_shift;
            end
        end
        else if (pend_e != 3'd0 && encoding_reg == ENC_UTF16)
        begin
            done_char = 1'b1;
            done_cp   = (acc_e << 10) + unit_m + SURR_OFFSET;
        end
        else if (unit_m == 32'd0)
        begin
            pending_next  = 3'd0;
            finished_next = 1'b1;
            emit          = 1'b1;
        end
        else if (!skipping && (CMP_WIDTH'(index_e) >= CMP_WIDTH'(char_end_reg)
                               || budget_e[BUDGET_WIDTH-1] || budget_e == '0))
        begin
            pending_next  = 3'd0;
            finished_next = 1'b1;
            emit          = 1'b1;
        end
        else
        begin
            if (!skipping)
            begin
                budget_next = budget_e - BUDGET_WIDTH'(lead.cost);
            end
            if (lead.len == 3'd1)
            begin
                done_char = 1'b1;
                done_cp   = lead.init;
                done_kind = lead.bad ? KIND_BAD_LEAD : KIND_CODE_POINT;
            end
            else
            begin
                pending_next = lead.len - 3'd1;
                acc_next     = lead.init;
            end
        end

        if (done_char)
        begin
            pending_next = 3'd0;
            acc_next     = 32'd0;
            if (!(&index_e))
            begin
                index_next = index_e + COUNT_WIDTH'(1);
            end
            if (!skipping)
            begin
                emit      = 1'b1;
                emit_item = '{code_point: done_cp, kind: done_kind};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg     <= ENC_UTF8;
            skip_count_reg   <= 16'd0;
            char_end_reg     <= 16'hFFFF;
            byte_limit_reg   <= 16'hFFFF;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            pending_reg      <= 3'd0;
            acc_reg          <= 32'd0;
            index_reg        <= '0;
            budget_reg       <= BUDGET_WIDTH'(18'h0FFFF);
            finished_reg     <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                hold_valid_reg <= item_valid;
            end
            if (fire)
            begin
                result_valid_reg <= emit;
                index_reg        <= index_next;
                budget_reg       <= budget_next;
                finished_reg     <= finished_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_index == REG_ENCODING)
            begin
                pending_reg <= 3'd0;
                acc_reg     <= 32'd0;
            end
            else if (fire)
            begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ENCODING:   encoding_reg   <= cfg_data[1:0];
                    REG_SKIP_COUNT: skip_count_reg <= cfg_data;
                    REG_CHAR_END:   char_end_reg   <= cfg_data;
                    REG_BYTE_LIMIT: byte_limit_reg <= cfg_data;
                    default:        skip_count_reg <= skip_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hold_item_reg <= item;
        end
        if (fire && emit)
        begin
            result_reg <= emit_item;
        end
    end

endmodule

// ----- sv/utfcu_lead.sv -----
// Classifier for the first code unit of a character: length, budget cost and initial value.
module utfcu_lead (
    input  logic [1:0]          encoding,
    input  logic [31:0]         unit,
    output utfcu_pkg::lead_info_t info
);
    import utfcu_pkg::*;

    logic [7:0] lead_byte;

    assign lead_byte = unit[7:0];

    always_comb
    begin
        info.len  = 3'd1;
        info.cost = 3'd4;
        info.init = unit;
        info.bad  = 1'b0;
        unique case (encoding)
            ENC_UTF8:
            begin
                priority if (lead_byte[7] == 1'b0)
                begin
                    info.len  = 3'd1;
                    info.init = {24'd0, lead_byte};
                end
                else if ((lead_byte & 8'hE0) == 8'hC0)
                begin
                    info.len  = 3'd2;
                    info.init = {24'd0, lead_byte & 8'h1F};
                end
                else if ((lead_byte & 8'hF0) == 8'hE0)
                begin
                    info.len  = 3'd3;
                    info.init = {24'd0, lead_byte & 8'h0F};
                end
                else if ((lead_byte & 8'hF8) == 8'hF0)
                begin
                    info.len  = 3'd4;
                    info.init = {24'd0, lead_byte & 8'h07};
                end
                else if ((lead_byte & 8'hFC) == 8'hF8)
                begin
                    info.len  = 3'd5;
                    info.init = {24'd0, lead_byte & 8'h03};
                end
                else if ((lead_byte & 8'hFE) == 8'hFC)
                begin
                    info.len  = 3'd6;
                    info.init = {24'd0, lead_byte & 8'h01};
                end
                else
                begin
                    info.len  = 3'd1;
                    info.init = {24'd0, lead_byte};
                    info.bad  = 1'b1;
                end
                info.cost = info.len;
            end
            ENC_UTF16:
            begin
                info.init = {16'd0, unit[15:0]};
                if (unit[15:10] == 6'b110110)
                begin
                    info.len  = 3'd2;
                    info.cost = 3'd4;
                end
                else
                begin
                    info.len  = 3'd1;
                    info.cost = 3'd2;
                end
            end
            default:
            begin
                info.len  = 3'd1;
                info.cost = 3'd4;
                info.init = unit;
            end
        endcase
    end

endmodule

// ----- sv/utfcu_checker.sv -----
// Checker on the ports of the UTF code unit decoder, with its bind to the top level.
module utfcu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input utfcu_pkg::in_item_t  item,
    input logic                 result_valid,
    input logic                 result_ready,
    input utfcu_pkg::out_item_t result,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [1:0]           cfg_index,
    input logic [15:0]          cfg_data
);
    import utfcu_pkg::*;

    // A stalled result item must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    // With no result waiting, the decoder must be able to take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with an empty result register");

    // An end-of-string result carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_END |-> result.code_point == 32'd0)
        else $error("end of string with non-zero value");

    // A bad lead byte is always a byte from 0x80 upwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_BAD_LEAD
            |-> result.code_point[31:8] == 24'd0 && result.code_point[7])
        else $error("bad lead result is not a high byte");

endmodule

bind utf_code_unit_decoder_unit utfcu_checker u_utfcu_checker (.*);

// ----- sim/utf_decode_checker.sv -----
// Checker for the UTF code unit decoder: follows its state, predicts each result item and compares.
`timescale 1ns / 1ps
module utf_decode_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  utfcu_pkg::in_item_t  item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  utfcu_pkg::out_item_t result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   results_due,
    output int                   units_decoded,
    output int                   error_count
);
    import utfcu_pkg::*;

    logic [1:0]                     enc_reg;
    logic [15:0]                    skip_reg;
    logic [15:0]                    end_reg;
    logic [15:0]                    limit_reg;
    logic [2:0]                     units_owed;
    logic [31:0]                    partial_cp;
    logic [COUNT_WIDTH-1:0]         chars_done;
    logic signed [BUDGET_WIDTH-1:0] budget;
    logic                           stopped;
    out_item_t                      code_points_due[$];
    out_item_t                      want;

    task automatic push_result(input logic [31:0] cp, input logic [1:0] kind);
        out_item_t r;
        r.code_point = cp;
        r.kind = kind;
        code_points_due.push_back(r);
    endtask

    task automatic close_char(input logic [31:0] cp, input logic [1:0] kind);
        logic skipped;
        skipped = chars_done < skip_reg;
        if (chars_done != '1)
        begin
            chars_done = chars_done + 1'b1;
        end
        units_owed = '0;
        partial_cp = '0;
        if (!skipped)
        begin
            push_result(cp, kind);
        end
    endtask

    task automatic decode_unit(input in_item_t it);
        logic [31:0] u;
        logic [31:0] lead_val;
        logic [2:0]  len;
        logic        bad;
        logic        skipping;
        units_decoded = units_decoded + 1;
        if (it.restart)
        begin
            chars_done = '0;
            budget = BUDGET_WIDTH'(limit_reg);
            stopped = 1'b0;
            units_owed = '0;
            partial_cp = '0;
        end
        if (stopped)
        begin
            return;
        end
        case (enc_reg)
            ENC_UTF8:  u = {24'd0, it.unit[7:0]};
            ENC_UTF16: u = {16'd0, it.unit[15:0]};
            ENC_UTF32: u = it.unit;
            default:   return;
        endcase

        if (units_owed != 0)
        begin
            units_owed = units_owed - 1'b1;
            if (enc_reg == ENC_UTF8)
            begin
                partial_cp = (partial_cp << 6) + {26'd0, u[5:0]};
                if (units_owed == 0)
                begin
                    close_char(partial_cp, KIND_CODE_POINT);
                end
                return;
            end
            if (enc_reg == ENC_UTF16)
            begin
                close_char((partial_cp << 10) + u + SURR_OFFSET, KIND_CODE_POINT);
                return;
            end
            units_owed = '0;
        end

        if (u == 0)
        begin
            stopped = 1'b1;
            push_result(32'd0, KIND_END);
            return;
        end
        skipping = chars_done < skip_reg;
        if (!skipping && (chars_done >= end_reg || budget <= 0))
        begin
            stopped = 1'b1;
            push_result(32'd0, KIND_END);
            return;
        end

        bad = 1'b0;
        len = 3'd1;
        lead_val = u;
        case (enc_reg)
            ENC_UTF8:
            begin
                casez (u[7:0])
                    8'b0???????: len = 3'd1;
                    8'b110?????:
                    begin
                        len = 3'd2;
                        lead_val = {27'd0, u[4:0]};
                    end
                    8'b1110????:
                    begin
                        len = 3'd3;
                        lead_val = {28'd0, u[3:0]};
                    end
                    8'b11110???:
                    begin
                        len = 3'd4;
                        lead_val = {29'd0, u[2:0]};
                    end
                    8'b111110??:
                    begin
                        len = 3'd5;
                        lead_val = {30'd0, u[1:0]};
                    end
                    8'b1111110?:
                    begin
                        len = 3'd6;
                        lead_val = {31'd0, u[0]};
                    end
                    default: bad = 1'b1;
                endcase
                if (!skipping)
                begin
                    budget = budget - BUDGET_WIDTH'(len);
                end
            end
            ENC_UTF16:
            begin
                if (u[15:10] == 6'b110110)
                begin
                    len = 3'd2;
                end
                if (!skipping)
                begin
                    budget = budget - BUDGET_WIDTH'({len, 1'b0});
                end
            end
            default:
            begin
                if (!skipping)
                begin
                    budget = budget - BUDGET_WIDTH'(4);
                end
            end
        endcase

        if (len == 3'd1)
        begin
            close_char(lead_val, bad ? KIND_BAD_LEAD : KIND_CODE_POINT);
        end
        else
        begin
            units_owed = len - 1'b1;
            partial_cp = lead_val;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg = ENC_UTF8;
            skip_reg = 16'd0;
            end_reg = 16'hFFFF;
            limit_reg = 16'hFFFF;
            units_owed = '0;
            partial_cp = '0;
            chars_done = '0;
            budget = BUDGET_WIDTH'(16'hFFFF);
            stopped = 1'b0;
            code_points_due.delete();
            units_decoded = 0;
            error_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (code_points_due.size() == 0)
                begin
                    $error("result item with none expected: code_point %h kind %0d",
                           result.code_point, result.kind);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = code_points_due.pop_front();
                    if (result.code_point !== want.code_point)
                    begin
                        $error("code_point: expected %h, got %h",
                               want.code_point, result.code_point);
                        error_count = error_count + 1;
                    end
                    if (result.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, result.kind);
                        error_count = error_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENCODING:
                    begin
                        enc_reg = cfg_data[1:0];
                        units_owed = '0;
                        partial_cp = '0;
                    end
                    REG_SKIP_COUNT: skip_reg = cfg_data;
                    REG_CHAR_END:   end_reg = cfg_data;
                    REG_BYTE_LIMIT: limit_reg = cfg_data;
                    default:        ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                decode_unit(item);
            end
            results_due <= code_points_due.size();
        end
    end

endmodule

// ----- sim/utf_code_unit_decoder_unit_test.sv -----
// Testbench top for the UTF code unit decoder: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps
module utf_code_unit_decoder_unit_test;
    import utfcu_pkg::*;

    localparam int         SETTLE_CYCLES = 4;
    localparam int         UNIT_TARGET   = 1350;
    localparam int         CYCLE_LIMIT   = 400000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    in_item_t    item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_item_t   result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = REG_ENCODING;
    logic [15:0] cfg_data     = 16'd0;

    int          results_due;
    int          units_decoded;
    int          error_count;
    int          cycle_count  = 0;
    int          burst_left   = 0;
    int          ready_left   = 0;
    logic [31:0] unit_q[$];

    utf_code_unit_decoder_unit #(
        .COUNT_WIDTH(16)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    utf_decode_checker #(
        .COUNT_WIDTH(16)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .results_due  (results_due),
        .units_decoded(units_decoded),
        .error_count  (error_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (ready_left != 0)
        begin
            ready_left = ready_left - 1;
        end
        else if (result_ready)
        begin
            result_ready <= 1'b0;
            ready_left = $urandom_range(0, 5);
        end
        else
        begin
            result_ready <= 1'b1;
            ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
        end
    end

    function automatic logic [31:0] dirty(input logic [31:0] v, input logic [31:0] used_mask);
        if ($urandom_range(0, 3) == 0)
        begin
            return ($urandom & ~used_mask) | v;
        end
        return v;
    endfunction

    task automatic send_item(input logic [31:0] u, input logic restart);
        in_item_t it;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        it.unit = u;
        it.restart = restart;
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] enc, input logic [15:0] skip,
                             input logic [15:0] cend, input logic [15:0] blimit);
        write_reg(REG_ENCODING, {14'($urandom), enc});
        write_reg(REG_SKIP_COUNT, skip);
        write_reg(REG_CHAR_END, cend);
        write_reg(REG_BYTE_LIMIT, blimit);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic build_char(input logic [1:0] enc);
        int          pick;
        int          len;
        logic [7:0]  lead;
        logic [7:0]  cont;
        logic [15:0] hi;
        pick = $urandom_range(0, 19);
        hi = 16'hD800 + 16'($urandom_range(0, 1023));
        case (enc)
            ENC_UTF16:
            begin
                if (pick < 6)
                begin
                    unit_q.push_back(dirty(32'($urandom_range(1, 16'hD7FF)), 32'hFFFF));
                end
                else if (pick < 12)
                begin
                    unit_q.push_back(dirty(32'($urandom_range(16'hE000, 16'hFFFF)), 32'hFFFF));
                end
                else if (pick < 17)
                begin
                    unit_q.push_back(dirty({16'd0, hi}, 32'hFFFF));
                    unit_q.push_back(dirty(32'h0000DC00 + 32'($urandom_range(0, 1023)),
                                           32'hFFFF));
                end
                else if (pick < 19)
                begin
                    unit_q.push_back(dirty(32'h0000DC00 + 32'($urandom_range(0, 1023)),
                                           32'hFFFF));
                end
                else
                begin
                    unit_q.push_back(dirty({16'd0, hi}, 32'hFFFF));
                    unit_q.push_back(dirty({16'd0, 16'($urandom)}, 32'hFFFF));
                end
            end
            ENC_UTF32:
            begin
                if (pick < 12)
                begin
                    unit_q.push_back(32'($urandom_range(1, 32'h10FFFF)));
                end
                else if (pick < 17)
                begin
                    unit_q.push_back($urandom);
                end
                else
                begin
                    unit_q.push_back(32'($urandom_range(1, 127)));
                end
            end
            default:
            begin
                len = 1;
                if (pick < 8)
                begin
                    lead = 8'($urandom_range(1, 127));
                end
                else if (pick < 11)
                begin
                    len = 2;
                    lead = {3'b110, 5'($urandom)};
                end
                else if (pick < 14)
                begin
                    len = 3;
                    lead = {4'b1110, 4'($urandom)};
                end
                else if (pick < 16)
                begin
                    len = 4;
                    lead = {5'b11110, 3'($urandom)};
                end
                else if (pick == 16)
                begin
                    len = 5;
                    lead = {6'b111110, 2'($urandom)};
                end
                else if (pick == 17)
                begin
                    len = 6;
                    lead = {7'b1111110, 1'($urandom)};
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    lead = {7'b1111111, 1'($urandom)};
                end
                else
                begin
                    lead = {2'b10, 6'($urandom)};
                end
                unit_q.push_back(dirty({24'd0, lead}, 32'hFF));
                for (int i = 1; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        cont = 8'($urandom);
                    end
                    else
                    begin
                        cont = {2'b10, 6'($urandom)};
                    end
                    unit_q.push_back(dirty({24'd0, cont}, 32'hFF));
                end
            end
        endcase
    endtask

    task automatic send_string(input logic [1:0] enc);
        int          tail;
        logic        first;
        logic [31:0] zero_unit;
        unit_q.delete();
        repeat ($urandom_range(0, 12)) build_char(enc);
        tail = $urandom_range(0, 9);
        zero_unit = $urandom;
        case (enc)
            ENC_UTF8:  zero_unit[7:0] = 8'd0;
            ENC_UTF16: zero_unit[15:0] = 16'd0;
            default:   zero_unit = 32'd0;
        endcase
        if (tail < 7)
        begin
            unit_q.push_back(zero_unit);
        end
        else if (tail == 7 && unit_q.size() > 1)
        begin
            void'(unit_q.pop_back());
        end
        first = ($urandom_range(0, 9) != 0);
        foreach (unit_q[i])
        begin
            send_item(unit_q[i], first);
            first = 1'b0;
        end
        if (tail < 7 && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) send_item($urandom, 1'b0);
        end
    endtask

    initial
    begin
        int          pick;
        logic [1:0]  enc;
        logic [15:0] skip;
        logic [15:0] cend;
        logic [15:0] blimit;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(ENC_UTF8, 16'd1, 16'hFFFF, 16'hFFFF);
        send_item(32'h0000_00C3, 1'b1);
        send_item(32'h0000_00A9, 1'b0);
        send_item(32'h0000_007F, 1'b0);
        send_item(32'hA5A5_A5FD, 1'b0);
        send_item(32'h0000_00BF, 1'b0);
        send_item(32'h0000_003F, 1'b0);
        send_item(32'h0000_00FF, 1'b0);
        send_item(32'h0000_0080, 1'b0);
        send_item(32'h0000_00BF, 1'b0);
        send_item(32'h0000_00FE, 1'b0);
        send_item(32'hFFFF_FF00, 1'b0);

        wait_idle();
        configure(ENC_UTF16, 16'd0, 16'hFFFF, 16'd5);
        send_item(32'h0000_D83D, 1'b1);
        send_item(32'h0000_DE00, 1'b0);
        send_item(32'h0000_DC00, 1'b0);
        send_item(32'h0000_0041, 1'b0);
        send_item(32'h0000_0042, 1'b0);

        wait_idle();
        configure(ENC_UTF32, 16'd0, 16'd1, 16'hFFFF);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h0000_0001, 1'b0);

        wait_idle();
        configure(ENC_UNUSED, 16'd0, 16'hFFFF, 16'hFFFF);
        send_item(32'h0000_0041, 1'b1);

        wait_idle();
        configure(ENC_UTF8, 16'd0, 16'd0, 16'd0);
        send_item(32'h0000_0041, 1'b1);

        wait_idle();
        configure(ENC_UTF8, 16'd0, 16'hFFFF, 16'd0);
        send_item(32'h0000_0041, 1'b1);

        wait_idle();
        configure(ENC_UTF32, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(32'h0000_0041, 1'b1);
        send_item(32'h0000_0000, 1'b0);

        while (units_decoded < UNIT_TARGET)
        begin
            wait_idle();
            pick = $urandom_range(0, 15);
            if (pick < 6)
            begin
                enc = ENC_UTF8;
            end
            else if (pick < 11)
            begin
                enc = ENC_UTF16;
            end
            else if (pick < 15)
            begin
                enc = ENC_UTF32;
            end
            else
            begin
                enc = ENC_UNUSED;
            end
            pick = $urandom_range(0, 9);
            skip = (pick < 6) ? 16'd0 :
                   (pick < 8) ? 16'($urandom_range(1, 4)) :
                   (pick == 8) ? 16'hFFFF : 16'($urandom);
            pick = $urandom_range(0, 9);
            cend = (pick < 6) ? 16'hFFFF :
                   (pick < 9) ? 16'($urandom_range(0, 12)) : 16'($urandom);
            pick = $urandom_range(0, 9);
            blimit = (pick < 6) ? 16'hFFFF :
                     (pick < 9) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            configure(enc, skip, cend, blimit);
            repeat ($urandom_range(1, 5)) send_string(enc);
        end

        wait_idle();
        if (error_count == 0 && results_due == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
